// ===== design/pmi_pkg.sv =====
package pmi_pkg;

  localparam int MAX_DIMS   = 3;
  localparam int MAX_EXTENT = 15;

  // Field widths of the word layout.
  localparam int IDX_W  = 15;
  localparam int REG_W  = 4;
  localparam int ND_W   = 2;
  localparam int SEL_W  = 2;
  localparam int KE_W   = 10;
  localparam int DIFF_W = 6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NUM_DIMS = 2'd0;
  localparam logic [1:0] CFG_EXT_X    = 2'd1;
  localparam logic [1:0] CFG_EXT_Y    = 2'd2;
  localparam logic [1:0] CFG_EXT_Z    = 2'd3;

  // Internal widths derived from the largest extent.
  localparam int EXT_W  = $clog2(MAX_EXTENT + 1);
  localparam int RAD_W  = EXT_W + 1;
  localparam int CMP_W  = EXT_W + 2;
  localparam int SQ_W   = 2 * EXT_W;
  localparam int KS_W   = SQ_W + 2;

  // Reciprocal scaling: q = (x * RCP) >> RCP_SH underestimates x / r by at most one.
  localparam int RCP_SH = 21;
  localparam int RCP_W  = RCP_SH + 1;

  localparam logic [KE_W-1:0] KE_MAX = {KE_W{1'b1}};

  typedef logic signed [CMP_W-1:0] comp_t;

  // floor(2^21 / r) for the odd radices 1..63.
  function automatic logic [RCP_W-1:0] recip_of(input logic [5:0] r);
    logic [RCP_W-1:0] v;
    v = '0;
    unique case (r)
      6'd1:  v = 22'd2097152;
      6'd3:  v = 22'd699050;
      6'd5:  v = 22'd419430;
      6'd7:  v = 22'd299593;
      6'd9:  v = 22'd233016;
      6'd11: v = 22'd190650;
      6'd13: v = 22'd161319;
      6'd15: v = 22'd139810;
      6'd17: v = 22'd123361;
      6'd19: v = 22'd110376;
      6'd21: v = 22'd99864;
      6'd23: v = 22'd91180;
      6'd25: v = 22'd83886;
      6'd27: v = 22'd77672;
      6'd29: v = 22'd72315;
      6'd31: v = 22'd67650;
      6'd33: v = 22'd63550;
      6'd35: v = 22'd59918;
      6'd37: v = 22'd56679;
      6'd39: v = 22'd53773;
      6'd41: v = 22'd51150;
      6'd43: v = 22'd48770;
      6'd45: v = 22'd46603;
      6'd47: v = 22'd44620;
      6'd49: v = 22'd42799;
      6'd51: v = 22'd41120;
      6'd53: v = 22'd39568;
      6'd55: v = 22'd38130;
      6'd57: v = 22'd36792;
      6'd59: v = 22'd35544;
      6'd61: v = 22'd34379;
      6'd63: v = 22'd33288;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/planewave_momentum_index_unit_top.sv =====
// Channel   Direction  Ports
// --------  ---------  --------------------------------------------------------
// in        input      in_valid, in_stall, in_idx_a..in_idx_d, in_dim_select
// out       output     out_valid, out_stall, result fields out_*
// cfg       input      cfg_we, cfg_index, cfg_wdata
//
// Eleven register stages; one word enters and one leaves per cycle while out_stall
// is low. A word accepted into stage 1 is registered at each stage in turn, from
// capture through the output word stage, whose registers drive the outputs.
// The index split uses two reciprocal divisions, each a multiply, a multiply
// and subtract, and a correction stage; these set the depth.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register defaults.
// A stage advances when the stage after it is empty or advancing, so a stalled
// output holds its word while bubbles ahead of it still fill.
module planewave_momentum_index_unit_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pmi_pkg::IDX_W-1:0]   in_idx_a,
  input  logic [pmi_pkg::IDX_W-1:0]   in_idx_b,
  input  logic [pmi_pkg::IDX_W-1:0]   in_idx_c,
  input  logic [pmi_pkg::IDX_W-1:0]   in_idx_d,
  input  logic [pmi_pkg::SEL_W-1:0]   in_dim_select,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pmi_pkg::KE_W-1:0]    out_sq_momentum,
  output logic                        out_one_body_conserved,
  output logic                        out_two_body_conserved,
  output logic signed [pmi_pkg::DIFF_W-1:0] out_diff_x,
  output logic signed [pmi_pkg::DIFF_W-1:0] out_diff_y,
  output logic signed [pmi_pkg::DIFF_W-1:0] out_diff_z,
  output logic signed [pmi_pkg::DIFF_W-1:0] out_selected_diff,
  output logic [pmi_pkg::IDX_W-1:0]   out_diff_index,
  output logic                        out_diff_in_range,
  output logic                        out_index_error,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [pmi_pkg::REG_W-1:0]   cfg_wdata
);

  localparam int NS    = 11;
  localparam int IDX_W = pmi_pkg::IDX_W;
  localparam int RAD_W = pmi_pkg::RAD_W;
  localparam int EXT_W = pmi_pkg::EXT_W;
  localparam int CMP_W = pmi_pkg::CMP_W;
  localparam int SQ_W  = pmi_pkg::SQ_W;
  localparam int RCP_W = pmi_pkg::RCP_W;
  localparam int RCP_SH = pmi_pkg::RCP_SH;
  localparam int H_W   = 2 * RAD_W + 1;

  localparam logic [1:0] CFG_NUM_DIMS = pmi_pkg::CFG_NUM_DIMS;
  localparam logic [1:0] CFG_EXT_X    = pmi_pkg::CFG_EXT_X;
  localparam logic [1:0] CFG_EXT_Y    = pmi_pkg::CFG_EXT_Y;
  localparam logic [1:0] CFG_EXT_Z    = pmi_pkg::CFG_EXT_Z;

  // ---------------- configuration ----------------
  logic [pmi_pkg::ND_W-1:0]  nd_r;
  logic [pmi_pkg::REG_W-1:0] ext_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_r <= pmi_pkg::ND_W'(3);
      for (int k = 0; k < 3; k++) ext_r[k] <= pmi_pkg::REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_DIMS: nd_r     <= pmi_pkg::ND_W'(cfg_wdata);
        CFG_EXT_X:    ext_r[0] <= cfg_wdata;
        CFG_EXT_Y:    ext_r[1] <= cfg_wdata;
        CFG_EXT_Z:    ext_r[2] <= cfg_wdata;
        default:      nd_r     <= nd_r;
      endcase
    end
  end

  logic [1:0]       nd;
  logic [EXT_W-1:0] ext [3];
  logic [RAD_W-1:0] rad [3];
  logic             use1, use2;
  logic [RAD_W-1:0] div_a, div_b, mul1, mul2;
  logic [RCP_W-1:0] rcp_a, rcp_b;
  logic [IDX_W:0]   basis_size;

  always_comb begin
    nd = nd_r;
    if (nd == 2'd0) nd = 2'd1;
    if (32'(nd) > pmi_pkg::MAX_DIMS) nd = 2'(pmi_pkg::MAX_DIMS);
    for (int k = 0; k < 3; k++) begin
      ext[k] = (32'(ext_r[k]) > pmi_pkg::MAX_EXTENT) ? EXT_W'(pmi_pkg::MAX_EXTENT)
                                                     : EXT_W'(ext_r[k]);
      rad[k] = {ext[k], 1'b1};
    end
    use1  = (nd >= 2'd2);
    use2  = (nd == 2'd3);
    div_a = use2 ? rad[2] : (use1 ? rad[1] : RAD_W'(1));
    div_b = use2 ? rad[1] : RAD_W'(1);
    mul1  = use1 ? rad[1] : RAD_W'(1);
    mul2  = use2 ? rad[2] : RAD_W'(1);
    rcp_a = pmi_pkg::recip_of(6'(div_a));
    rcp_b = pmi_pkg::recip_of(6'(div_b));
    basis_size = (IDX_W+1)'(rad[0] * mul1 * mul2);
  end

  // ---------------- flow control ----------------
  logic [NS:1] v_r;
  logic [NS+1:1] rdy;

  always_comb begin
    rdy[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NS; k++) if (rdy[k]) v_r[k] <= v_r[k-1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v_r[NS];

  // ---------------- stage 1: capture ----------------
  logic [IDX_W-1:0] s1_idx_r [4];
  logic [1:0]       s1_sel_r;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_idx_r[0] <= in_idx_a;
      s1_idx_r[1] <= in_idx_b;
      s1_idx_r[2] <= in_idx_c;
      s1_idx_r[3] <= in_idx_d;
      s1_sel_r    <= in_dim_select;
    end
  end

  // ---------------- stage 2: range check, first quotient estimate ----------------
  logic [IDX_W-1:0] s2_idx_r [4];
  logic [IDX_W-1:0] s2_q_r [4];
  logic             s2_err_r;
  logic [1:0]       s2_sel_r;
  logic [IDX_W-1:0] s2_q_nxt [4];
  logic             s2_err_nxt;
  always_comb begin
    s2_err_nxt = 1'b0;
    for (int q = 0; q < 4; q++) begin
      if ({1'b0, s1_idx_r[q]} >= basis_size) s2_err_nxt = 1'b1;
      s2_q_nxt[q] = IDX_W'((IDX_W+RCP_W)'(s1_idx_r[q] * rcp_a) >> RCP_SH);
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_idx_r <= s1_idx_r;
      s2_q_r   <= s2_q_nxt;
      s2_err_r <= s2_err_nxt;
      s2_sel_r <= s1_sel_r;
    end
  end

  // ---------------- stage 3: first remainder ----------------
  logic [IDX_W-1:0] s3_q_r [4];
  logic [RAD_W:0]   s3_rem_r [4];
  logic             s3_err_r;
  logic [1:0]       s3_sel_r;
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int q = 0; q < 4; q++)
        s3_rem_r[q] <= (RAD_W+1)'(s2_idx_r[q] - IDX_W'(s2_q_r[q] * div_a));
      s3_q_r   <= s2_q_r;
      s3_err_r <= s2_err_r;
      s3_sel_r <= s2_sel_r;
    end
  end

  // ---------------- stage 4: first correction ----------------
  logic [IDX_W-1:0] s4_q_r [4];
  logic [RAD_W-1:0] s4_rem_r [4];
  logic             s4_err_r;
  logic [1:0]       s4_sel_r;
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int q = 0; q < 4; q++) begin
        if (s3_rem_r[q] >= {1'b0, div_a}) begin
          s4_q_r[q]   <= s3_q_r[q] + IDX_W'(1);
          s4_rem_r[q] <= RAD_W'(s3_rem_r[q] - {1'b0, div_a});
        end else begin
          s4_q_r[q]   <= s3_q_r[q];
          s4_rem_r[q] <= RAD_W'(s3_rem_r[q]);
        end
      end
      s4_err_r <= s3_err_r;
      s4_sel_r <= s3_sel_r;
    end
  end

  // ---------------- stage 5: second quotient estimate ----------------
  logic [IDX_W-1:0] s5_n_r [4];
  logic [IDX_W-1:0] s5_q_r [4];
  logic [RAD_W-1:0] s5_ra_r [4];
  logic             s5_err_r;
  logic [1:0]       s5_sel_r;
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int q = 0; q < 4; q++)
        s5_q_r[q] <= IDX_W'((IDX_W+RCP_W)'(s4_q_r[q] * rcp_b) >> RCP_SH);
      s5_n_r   <= s4_q_r;
      s5_ra_r  <= s4_rem_r;
      s5_err_r <= s4_err_r;
      s5_sel_r <= s4_sel_r;
    end
  end

  // ---------------- stage 6: second remainder ----------------
  logic [IDX_W-1:0] s6_q_r [4];
  logic [RAD_W:0]   s6_rem_r [4];
  logic [RAD_W-1:0] s6_ra_r [4];
  logic             s6_err_r;
  logic [1:0]       s6_sel_r;
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int q = 0; q < 4; q++)
        s6_rem_r[q] <= (RAD_W+1)'(s5_n_r[q] - IDX_W'(s5_q_r[q] * div_b));
      s6_q_r   <= s5_q_r;
      s6_ra_r  <= s5_ra_r;
      s6_err_r <= s5_err_r;
      s6_sel_r <= s5_sel_r;
    end
  end

  // ---------------- stage 7: second correction, digits ----------------
  logic [RAD_W-1:0] s7_d0_r [4];
  logic [RAD_W-1:0] s7_rb_r [4];
  logic [RAD_W-1:0] s7_ra_r [4];
  logic             s7_err_r;
  logic [1:0]       s7_sel_r;
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int q = 0; q < 4; q++) begin
        if (s6_rem_r[q] >= {1'b0, div_b}) begin
          s7_d0_r[q] <= RAD_W'(s6_q_r[q] + IDX_W'(1));
          s7_rb_r[q] <= RAD_W'(s6_rem_r[q] - {1'b0, div_b});
        end else begin
          s7_d0_r[q] <= RAD_W'(s6_q_r[q]);
          s7_rb_r[q] <= RAD_W'(s6_rem_r[q]);
        end
      end
      s7_ra_r  <= s6_ra_r;
      s7_err_r <= s6_err_r;
      s7_sel_r <= s6_sel_r;
    end
  end

  // ---------------- stage 8: momentum components ----------------
  pmi_pkg::comp_t s8_c_r [4][3];
  logic           s8_err_r;
  logic [1:0]     s8_sel_r;
  pmi_pkg::comp_t s8_c_nxt [4][3];
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      s8_c_nxt[q][0] = CMP_W'(s7_d0_r[q]) - CMP_W'(ext[0]);
      s8_c_nxt[q][1] = use2 ? CMP_W'(s7_rb_r[q]) - CMP_W'(ext[1])
                     : (use1 ? CMP_W'(s7_ra_r[q]) - CMP_W'(ext[1]) : '0);
      s8_c_nxt[q][2] = use2 ? CMP_W'(s7_ra_r[q]) - CMP_W'(ext[2]) : '0;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_c_r   <= s8_c_nxt;
      s8_err_r <= s7_err_r;
      s8_sel_r <= s7_sel_r;
    end
  end

  // ---------------- stage 9: squares, checks, differences ----------------
  logic [SQ_W-1:0]  s9_sq_r [3];
  pmi_pkg::comp_t   s9_dif_r [3];
  logic [RAD_W-1:0] s9_dd_r [3];
  pmi_pkg::comp_t   s9_seld_r;
  logic             s9_one_r, s9_two_r, s9_inr_r, s9_err_r;
  pmi_pkg::comp_t   s9_dif_nxt [3];
  logic             s9_one_nxt, s9_two_nxt, s9_inr_nxt;
  logic signed [CMP_W:0] ab, cd;
  always_comb begin
    s9_one_nxt = 1'b1;
    s9_two_nxt = 1'b1;
    s9_inr_nxt = 1'b1;
    ab = '0;
    cd = '0;
    for (int k = 0; k < 3; k++) begin
      s9_dif_nxt[k] = s8_c_r[0][k] - s8_c_r[1][k];
      ab = (CMP_W+1)'(s8_c_r[0][k]) + (CMP_W+1)'(s8_c_r[1][k]);
      cd = (CMP_W+1)'(s8_c_r[2][k]) + (CMP_W+1)'(s8_c_r[3][k]);
      if (s8_c_r[0][k] != s8_c_r[1][k]) s9_one_nxt = 1'b0;
      if (ab != cd) s9_two_nxt = 1'b0;
      if (s9_dif_nxt[k] > $signed(CMP_W'(ext[k])) ||
          s9_dif_nxt[k] < -$signed(CMP_W'(ext[k]))) s9_inr_nxt = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      for (int k = 0; k < 3; k++) begin
        s9_sq_r[k] <= SQ_W'(s8_c_r[0][k] * s8_c_r[0][k]);
        s9_dd_r[k] <= RAD_W'(s9_dif_nxt[k] + CMP_W'(ext[k]));
      end
      s9_dif_r <= s9_dif_nxt;
      unique case (s8_sel_r)
        2'd0:    s9_seld_r <= s9_dif_nxt[0];
        2'd1:    s9_seld_r <= use1 ? s9_dif_nxt[1] : '0;
        2'd2:    s9_seld_r <= use2 ? s9_dif_nxt[2] : '0;
        default: s9_seld_r <= '0;
      endcase
      s9_one_r <= s9_one_nxt;
      s9_two_r <= s9_two_nxt;
      s9_inr_r <= s9_inr_nxt;
      s9_err_r <= s8_err_r;
    end
  end

  // ---------------- stage 10: energy sum, first Horner step ----------------
  logic [pmi_pkg::KE_W-1:0] s10_ke_r;
  logic [H_W-1:0]           s10_h_r;
  logic [RAD_W-1:0]         s10_dd2_r;
  pmi_pkg::comp_t           s10_dif_r [3];
  pmi_pkg::comp_t           s10_seld_r;
  logic                     s10_one_r, s10_two_r, s10_inr_r, s10_err_r;
  logic [pmi_pkg::KS_W-1:0] ke_sum;
  always_comb begin
    ke_sum = pmi_pkg::KS_W'(s9_sq_r[0]) + pmi_pkg::KS_W'(s9_sq_r[1])
           + pmi_pkg::KS_W'(s9_sq_r[2]);
  end
  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      s10_ke_r   <= (32'(ke_sum) > 32'(pmi_pkg::KE_MAX)) ? pmi_pkg::KE_MAX
                                                         : pmi_pkg::KE_W'(ke_sum);
      s10_h_r    <= H_W'(s9_dd_r[0] * mul1) + (use1 ? H_W'(s9_dd_r[1]) : '0);
      s10_dd2_r  <= use2 ? s9_dd_r[2] : '0;
      s10_dif_r  <= s9_dif_r;
      s10_seld_r <= s9_seld_r;
      s10_one_r  <= s9_one_r;
      s10_two_r  <= s9_two_r;
      s10_inr_r  <= s9_inr_r;
      s10_err_r  <= s9_err_r;
    end
  end

  // ---------------- stage 11: output word ----------------
  logic [pmi_pkg::KE_W-1:0]          s11_ke_r;
  logic                              s11_one_r, s11_two_r, s11_inr_r, s11_err_r;
  logic signed [pmi_pkg::DIFF_W-1:0] s11_dif_r [3];
  logic signed [pmi_pkg::DIFF_W-1:0] s11_seld_r;
  logic [IDX_W-1:0]                  s11_flat_r;
  logic                              ok;
  assign ok = !s10_err_r;
  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      s11_ke_r   <= ok ? s10_ke_r : '0;
      s11_one_r  <= ok && s10_one_r;
      s11_two_r  <= ok && s10_two_r;
      s11_inr_r  <= ok && s10_inr_r;
      s11_err_r  <= s10_err_r;
      for (int k = 0; k < 3; k++)
        s11_dif_r[k] <= ok ? pmi_pkg::DIFF_W'(s10_dif_r[k]) : '0;
      s11_seld_r <= ok ? pmi_pkg::DIFF_W'(s10_seld_r) : '0;
      s11_flat_r <= (ok && s10_inr_r)
                  ? IDX_W'(s10_h_r * mul2) + IDX_W'(s10_dd2_r) : '0;
    end
  end

  assign out_sq_momentum        = s11_ke_r;
  assign out_one_body_conserved = s11_one_r;
  assign out_two_body_conserved = s11_two_r;
  assign out_diff_x             = s11_dif_r[0];
  assign out_diff_y             = s11_dif_r[1];
  assign out_diff_z             = s11_dif_r[2];
  assign out_selected_diff      = s11_seld_r;
  assign out_diff_index         = s11_flat_r;
  assign out_diff_in_range      = s11_inr_r;
  assign out_index_error        = s11_err_r;

  // ---------------- assertions ----------------
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_error) |->
      (out_sq_momentum == '0 && !out_one_body_conserved && !out_diff_in_range
       && out_diff_index == '0))
    else $error("error word carries a payload");

  a_range_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_diff_in_range) |-> (out_diff_index == '0))
    else $error("out-of-range difference has nonzero index");

  a_one_body: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_one_body_conserved) |->
      (out_diff_x == '0 && out_diff_y == '0 && out_diff_z == '0 && out_diff_in_range))
    else $error("equal momenta with nonzero difference");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W  = pmi_pkg::IDX_W;
  localparam int REG_W  = pmi_pkg::REG_W;
  localparam int ND_W   = pmi_pkg::ND_W;
  localparam int SEL_W  = pmi_pkg::SEL_W;
  localparam int KE_W   = pmi_pkg::KE_W;
  localparam int DIFF_W = pmi_pkg::DIFF_W;

  localparam logic [1:0] REG_NUM_DIMS = pmi_pkg::CFG_NUM_DIMS;
  localparam logic [1:0] REG_EXTENT_X = pmi_pkg::CFG_EXT_X;
  localparam logic [1:0] REG_EXTENT_Y = pmi_pkg::CFG_EXT_Y;
  localparam logic [1:0] REG_EXTENT_Z = pmi_pkg::CFG_EXT_Z;
  localparam int PIPE_DRAIN = 20;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [KE_W-1:0]          ke;
    logic                     one_body;
    logic                     two_body;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic signed [DIFF_W-1:0] sel_diff;
    logic [IDX_W-1:0]         diff_idx;
    logic                     in_range;
    logic                     idx_err;
  } momentum_t;

  class momentum_scoreboard;
    logic [ND_W-1:0]  num_dims;
    logic [REG_W-1:0] extent[3];
    momentum_t        pending_q[$];
    int               errors;

    function new();
      num_dims = 2'd3;
      foreach (extent[k]) extent[k] = 4'd1;
      errors = 0;
    endfunction

    function int dims_used();
      return (num_dims == 0) ? 1 : int'(num_dims);
    endfunction

    function int basis_size();
      int sz;
      sz = 1;
      for (int k = 0; k < dims_used(); k++) sz *= 2 * int'(extent[k]) + 1;
      return sz;
    endfunction

    // Works out the expected word for one accepted input word.
    function void note_input(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                             logic [IDX_W-1:0] c, logic [IDX_W-1:0] d,
                             logic [SEL_W-1:0] sel);
      int nd, sz, v, r, n, ke, flat;
      int ix[4];
      int mom[4][3];
      int dif[3];
      bit one, two, inr;
      momentum_t e;
      nd = dims_used();
      sz = basis_size();
      ix[0] = a; ix[1] = b; ix[2] = c; ix[3] = d;
      e = '{default: '0};
      if (ix[0] >= sz || ix[1] >= sz || ix[2] >= sz || ix[3] >= sz) begin
        e.idx_err = 1'b1;
        pending_q = {pending_q, e};
        return;
      end
      for (int q = 0; q < 4; q++) begin
        for (int k = 0; k < 3; k++) mom[q][k] = 0;
        v = ix[q];
        for (int k = nd - 1; k >= 0; k--) begin
          r = 2 * int'(extent[k]) + 1;
          mom[q][k] = v % r - int'(extent[k]);
          v = v / r;
        end
      end
      ke = 0; one = 1; two = 1; inr = 1; flat = 0;
      for (int k = 0; k < 3; k++) dif[k] = 0;
      for (int k = 0; k < nd; k++) begin
        n = extent[k];
        ke += mom[0][k] * mom[0][k];
        if (mom[0][k] != mom[1][k]) one = 0;
        if (mom[0][k] + mom[1][k] != mom[2][k] + mom[3][k]) two = 0;
        dif[k] = mom[0][k] - mom[1][k];
        if (dif[k] < -n || dif[k] > n) inr = 0;
      end
      if (inr) begin
        for (int k = 0; k < nd; k++)
          flat = flat * (2 * int'(extent[k]) + 1) + dif[k] + int'(extent[k]);
      end
      e.ke       = (ke > 1023) ? 10'd1023 : ke[KE_W-1:0];
      e.one_body = one;
      e.two_body = two;
      e.dx       = dif[0][DIFF_W-1:0];
      e.dy       = dif[1][DIFF_W-1:0];
      e.dz       = dif[2][DIFF_W-1:0];
      e.sel_diff = (int'(sel) < nd) ? dif[sel][DIFF_W-1:0] : '0;
      e.diff_idx = flat[IDX_W-1:0];
      e.in_range = inr;
      pending_q = {pending_q, e};
    endfunction

    function void compare(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(momentum_t got);
      momentum_t e;
      if (pending_q.size() == 0) begin
        $error("result word with no expected word waiting");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      compare("sq_momentum", e.ke, got.ke);
      compare("one_body_conserved", e.one_body, got.one_body);
      compare("two_body_conserved", e.two_body, got.two_body);
      compare("diff_x", e.dx, got.dx);
      compare("diff_y", e.dy, got.dy);
      compare("diff_z", e.dz, got.dz);
      compare("selected_diff", e.sel_diff, got.sel_diff);
      compare("diff_index", e.diff_idx, got.diff_idx);
      compare("diff_in_range", e.in_range, got.in_range);
      compare("index_error", e.idx_err, got.idx_err);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IDX_W-1:0] in_idx_a = '0, in_idx_b = '0, in_idx_c = '0, in_idx_d = '0;
  logic [SEL_W-1:0] in_dim_select = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KE_W-1:0] out_sq_momentum;
  logic out_one_body_conserved, out_two_body_conserved;
  logic signed [DIFF_W-1:0] out_diff_x, out_diff_y, out_diff_z, out_selected_diff;
  logic [IDX_W-1:0] out_diff_index;
  logic out_diff_in_range, out_index_error;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  momentum_scoreboard sb = new();
  bit send_quiet = 0;
  bit recv_quiet = 0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  planewave_momentum_index_unit_top i_dut (.*);

  task automatic write_reg(logic [1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_NUM_DIMS) sb.num_dims = val[ND_W-1:0];
    else sb.extent[idx - 1] = val;
  endtask

  task automatic configure(int nd, int ex, int ey, int ez);
    write_reg(REG_NUM_DIMS, REG_W'(nd));
    write_reg(REG_EXTENT_X, REG_W'(ex));
    write_reg(REG_EXTENT_Y, REG_W'(ey));
    write_reg(REG_EXTENT_Z, REG_W'(ez));
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // Drives one word and returns once it has been accepted.
  task automatic send_word(int a, int b, int c, int d, int sel);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_idx_a <= IDX_W'(a); in_idx_b <= IDX_W'(b);
    in_idx_c <= IDX_W'(c); in_idx_d <= IDX_W'(d);
    in_dim_select <= SEL_W'(sel);
    do @(posedge clk); while (in_stall);
    sb.note_input(IDX_W'(a), IDX_W'(b), IDX_W'(c), IDX_W'(d), SEL_W'(sel));
  endtask

  function automatic int pick_index(int sz);
    if ($urandom_range(0, 99) < 3) return $urandom_range(0, 32767);
    return $urandom_range(0, sz - 1);
  endfunction

  task automatic run_phase(int nd, int ex, int ey, int ez, int count);
    int sz, a, b, c, d, t;
    configure(nd, ex, ey, ez);
    sz = sb.basis_size();
    // Corners of the basis, every selector, an index just past the end and the largest index.
    send_word(0, 0, 0, 0, 0);
    send_word(sz - 1, sz - 1, sz - 1, sz - 1, 1);
    send_word(0, sz - 1, sz - 1, 0, 2);
    send_word(sz - 1, 0, 0, sz - 1, 3);
    send_word(sz / 2, sz / 2, 0, sz - 1, 0);
    send_word(sz, 0, 0, 0, 1);
    send_word(0, 0, 0, 32767, 2);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      a = pick_index(sz); b = pick_index(sz);
      c = pick_index(sz); d = pick_index(sz);
      t = $urandom_range(0, 9);
      if (t < 2) b = a;
      else if (t < 4) begin c = a; d = b; end
      else if (t < 6) begin c = b; d = a; end
      send_word(a, b, c, d, $urandom_range(0, 3));
    end
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  initial begin
    momentum_t got;
    int n, cnt;
    cnt = 0;
    @(posedge rst_n);
    forever begin
      if (cnt++ % 50 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      n = recv_quiet ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      got.ke = out_sq_momentum;
      got.one_body = out_one_body_conserved;
      got.two_body = out_two_body_conserved;
      got.dx = out_diff_x;
      got.dy = out_diff_y;
      got.dz = out_diff_z;
      got.sel_diff = out_selected_diff;
      got.diff_idx = out_diff_index;
      got.in_range = out_diff_in_range;
      got.idx_err = out_index_error;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    run_phase(3, 15, 15, 15, 210);
    run_phase(0, 0, 9, 9, 60);
    run_phase(1, 15, 0, 0, 120);
    run_phase(2, 15, 15, 0, 150);
    run_phase(3, 0, 0, 0, 60);
    run_phase(3, 1, 1, 1, 150);
    run_phase(2, 3, 7, 2, 150);
    run_phase(3, 15, 0, 15, 150);
    run_phase(1, 5, 12, 4, 80);
    run_phase(3, 4, 9, 15, 150);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
